// ----- src/pdm_pkg.sv -----
package pdm_pkg;

  // port phases
  localparam logic [2:0] PH_NC      = 3'd0;
  localparam logic [2:0] PH_ERR     = 3'd1;
  localparam logic [2:0] PH_CONN    = 3'd2;
  localparam logic [2:0] PH_SCANOFF = 3'd3;
  localparam logic [2:0] PH_IDENT   = 3'd4;
  localparam logic [2:0] PH_READY   = 3'd5;

  // input operations
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // result kinds
  localparam logic [1:0] RK_CMD   = 2'd0;
  localparam logic [1:0] RK_DATA  = 2'd1;
  localparam logic [1:0] RK_IDENT = 2'd2;

  // device kinds
  localparam logic [2:0] DEV_UNKNOWN = 3'd0;
  localparam logic [2:0] DEV_KBD     = 3'd1;
  localparam logic [2:0] DEV_MOUSE   = 3'd2;
  localparam logic [2:0] DEV_SCROLL  = 3'd3;
  localparam logic [2:0] DEV_MOUSE5  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SECOND_PORT = 2'd0;
  localparam logic [1:0] CFG_ID_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_TICK_MS     = 2'd2;
  localparam logic [1:0] CFG_MAX_PING    = 2'd3;

  localparam int CFG_DATA_W = 16;
  localparam int ID_TO_W    = 10;
  localparam int TICK_W     = 7;
  localparam int PING_W     = 16;

  localparam logic [ID_TO_W-1:0] ID_TIMEOUT_RST = 10'd20;
  localparam logic [TICK_W-1:0]  TICK_MS_RST    = 7'd5;
  localparam logic [PING_W-1:0]  MAX_PING_RST   = 16'd3000;

  // device and host bytes
  localparam logic [7:0] B_BAT_OK     = 8'hAA;
  localparam logic [7:0] B_BAT_FAIL   = 8'hFC;
  localparam logic [7:0] B_ACK        = 8'hFA;
  localparam logic [7:0] B_ECHO       = 8'hEE;
  localparam logic [7:0] B_RESEND     = 8'hFE;
  localparam logic [7:0] B_DISABLE    = 8'hF5;
  localparam logic [7:0] B_IDENTIFY   = 8'hF2;
  localparam logic [7:0] B_RESET      = 8'hFF;
  localparam logic [7:0] ID_KBD_HI    = 8'hAB;
  localparam logic [7:0] ID_KBD_TR    = 8'h83;
  localparam logic [7:0] ID_KBD_LO    = 8'h41;
  localparam logic [7:0] ID_KBD_LO2   = 8'hC1;
  localparam logic [7:0] ID_MOUSE     = 8'h00;
  localparam logic [7:0] ID_SCROLL    = 8'h03;
  localparam logic [7:0] ID_MOUSE5    = 8'h04;

  localparam int ID_DEPTH_DEF = 4;
  localparam int Q_DEPTH_DEF  = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic       port;
    logic [7:0] value;
    logic [2:0] dev;
    logic       translated;
    logic       supported;
  } result_t;

  // results of one input item: one or two
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } group_t;

endpackage

// ----- src/pdm_front.sv -----
module pdm_front #(
  parameter int ID_DEPTH = pdm_pkg::ID_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [pdm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic [1:0]                      op,
  input  logic                            port,
  input  logic [7:0]                      data,
  output logic                            grp_valid,
  output pdm_pkg::group_t                 grp
);
  import pdm_pkg::*;

  localparam int IDC_W = $clog2(ID_DEPTH + 1);
  localparam int IA_W  = $clog2(ID_DEPTH);

  typedef struct packed {
    logic [2:0] dev;
    logic       tr;
    logic       sup;
  } cls_t;

  // configuration
  logic                second_port;
  logic [ID_TO_W-1:0]  id_timeout;
  logic [TICK_W-1:0]   tick_ms;
  logic [PING_W-1:0]   max_ping;

  // per-port state
  logic [2:0]       phase [2];
  logic [2:0]       phase_next [2];
  logic [2:0]       dkind [2];
  logic [2:0]       dkind_next [2];
  logic             sup [2];
  logic             sup_next [2];
  logic             linked [2];
  logic             linked_next [2];
  logic [31:0]      echo [2];
  logic [31:0]      echo_next [2];
  logic [IDC_W-1:0] idc [2];
  logic [IDC_W-1:0] idc_next [2];
  logic [ID_TO_W-1:0] tleft [2];
  logic [ID_TO_W-1:0] tleft_next [2];
  logic             armed [2];
  logic             armed_next [2];
  logic [31:0]      now;
  logic [31:0]      now_next;
  logic [7:0]       idb [2][ID_DEPTH];

  logic             idb_we;
  logic [IA_W-1:0]  idb_addr;
  cls_t             cls [2];

  function automatic cls_t classify(logic [IDC_W-1:0] n, logic [7:0] b0, logic [7:0] b1);
    cls_t c;
    c = '{dev: DEV_UNKNOWN, tr: 1'b0, sup: 1'b0};
    if (n == '0) begin
      c = '{dev: DEV_KBD, tr: 1'b0, sup: 1'b1};
    end else if (n == IDC_W'(1)) begin
      if (b0 == ID_MOUSE)       c = '{dev: DEV_MOUSE,  tr: 1'b0, sup: 1'b1};
      else if (b0 == ID_SCROLL) c = '{dev: DEV_SCROLL, tr: 1'b0, sup: 1'b1};
      else if (b0 == ID_MOUSE5) c = '{dev: DEV_MOUSE5, tr: 1'b0, sup: 1'b1};
    end else if (n == IDC_W'(2) && b0 == ID_KBD_HI) begin
      if (b1 == ID_KBD_LO || b1 == ID_KBD_LO2) c = '{dev: DEV_KBD, tr: 1'b0, sup: 1'b1};
      else if (b1 == ID_KBD_TR)                c = '{dev: DEV_KBD, tr: 1'b1, sup: 1'b1};
    end
    return c;
  endfunction

  function automatic result_t mk(logic [1:0] k, logic p, logic [7:0] v, logic [2:0] d,
                                 logic tr, logic s);
    result_t r;
    r = '{kind: k, port: p, value: v, dev: d, translated: tr, supported: s};
    return r;
  endfunction

  always_comb begin
    for (int q = 0; q < 2; q++) begin
      cls[q] = classify(idc[q], idb[q][0], idb[q][1]);
    end
  end

  always_comb begin
    logic fire0;
    logic fire1;
    phase_next  = phase;
    dkind_next  = dkind;
    sup_next    = sup;
    linked_next = linked;
    echo_next   = echo;
    idc_next    = idc;
    tleft_next  = tleft;
    armed_next  = armed;
    now_next    = now;
    idb_we      = 1'b0;
    idb_addr    = idc[port][IA_W-1:0];
    grp         = '0;
    grp_valid   = 1'b0;
    fire0       = 1'b0;
    fire1       = 1'b0;
    if (accept) begin
      case (op)
        OP_BYTE: begin
          linked_next[port] = 1'b1;
          if (phase[port] == PH_NC && data != B_BAT_OK && data != B_BAT_FAIL) begin
            // keyboard already set up by firmware
            phase_next[port] = PH_READY;
            sup_next[port]   = 1'b1;
            dkind_next[port] = DEV_KBD;
            grp_valid = 1'b1;
            grp.two   = 1'b1;
            grp.r0    = mk(RK_IDENT, port, 8'h00, DEV_KBD, 1'b1, 1'b1);
            grp.r1    = mk(RK_DATA, port, data, DEV_UNKNOWN, 1'b0, 1'b0);
          end else if (data == B_ECHO) begin
            echo_next[port] = now;
          end else if (data == B_RESEND) begin
            grp_valid = 1'b0;
          end else if (data == B_BAT_OK) begin
            phase_next[port] = PH_CONN;
            grp_valid = 1'b1;
            grp.r0    = mk(RK_CMD, port, B_DISABLE, DEV_UNKNOWN, 1'b0, 1'b0);
          end else if (data == B_BAT_FAIL) begin
            phase_next[port] = PH_ERR;
            grp_valid = 1'b1;
            grp.r0    = mk(RK_CMD, port, B_RESET, DEV_UNKNOWN, 1'b0, 1'b0);
          end else if (data == B_ACK) begin
            if (phase[port] == PH_CONN) begin
              phase_next[port] = PH_SCANOFF;
              grp_valid = 1'b1;
              grp.r0    = mk(RK_CMD, port, B_IDENTIFY, DEV_UNKNOWN, 1'b0, 1'b0);
            end else if (phase[port] == PH_SCANOFF) begin
              phase_next[port] = PH_IDENT;
              idc_next[port]   = '0;
              tleft_next[port] = id_timeout;
              armed_next[port] = 1'b1;
            end
          end else if (phase[port] == PH_IDENT) begin
            if (idc[port] < IDC_W'(ID_DEPTH)) begin
              idb_we         = 1'b1;
              idc_next[port] = idc[port] + IDC_W'(1);
            end
          end else if (phase[port] == PH_READY && sup[port] && dkind[port] == DEV_KBD) begin
            grp_valid = 1'b1;
            grp.r0    = mk(RK_DATA, port, data, DEV_UNKNOWN, 1'b0, 1'b0);
          end
        end
        OP_TICK: begin
          now_next = now + 32'(tick_ms);
          for (int q = 0; q < 2; q++) begin
            if (armed[q]) begin
              if (tleft[q] != '0) begin
                tleft_next[q] = (tleft[q] > ID_TO_W'(tick_ms)) ?
                                tleft[q] - ID_TO_W'(tick_ms) : '0;
              end else begin
                armed_next[q] = 1'b0;
                phase_next[q] = PH_READY;
                dkind_next[q] = cls[q].dev;
                sup_next[q]   = cls[q].sup;
              end
            end
          end
          fire0 = armed[0] && tleft[0] == '0;
          fire1 = armed[1] && tleft[1] == '0;
          grp_valid = fire0 | fire1;
          grp.two   = fire0 & fire1;
          grp.r0    = fire0 ? mk(RK_IDENT, 1'b0, 8'h00, cls[0].dev, cls[0].tr, cls[0].sup)
                            : mk(RK_IDENT, 1'b1, 8'h00, cls[1].dev, cls[1].tr, cls[1].sup);
          grp.r1    = mk(RK_IDENT, 1'b1, 8'h00, cls[1].dev, cls[1].tr, cls[1].sup);
        end
        OP_CHECK: begin
          for (int q = 0; q < 2; q++) begin
            if ((q == 0 || second_port) && (now - echo[q]) > 32'(max_ping)) begin
              dkind_next[q]  = DEV_UNKNOWN;
              phase_next[q]  = PH_NC;
              linked_next[q] = 1'b0;
            end
          end
          grp_valid = 1'b1;
          grp.two   = second_port;
          grp.r0    = mk(RK_CMD, 1'b0, linked_next[0] ? B_ECHO : B_RESET,
                         DEV_UNKNOWN, 1'b0, 1'b0);
          grp.r1    = mk(RK_CMD, 1'b1, linked_next[1] ? B_ECHO : B_RESET,
                         DEV_UNKNOWN, 1'b0, 1'b0);
        end
        default: begin
          grp_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_port <= 1'b0;
      id_timeout  <= ID_TIMEOUT_RST;
      tick_ms     <= TICK_MS_RST;
      max_ping    <= MAX_PING_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SECOND_PORT: second_port <= cfg_data[0];
        CFG_ID_TIMEOUT:  id_timeout  <= cfg_data[ID_TO_W-1:0];
        CFG_TICK_MS:     tick_ms     <= cfg_data[TICK_W-1:0];
        CFG_MAX_PING:    max_ping    <= cfg_data[PING_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < 2; q++) begin
        phase[q]  <= PH_NC;
        dkind[q]  <= DEV_UNKNOWN;
        sup[q]    <= 1'b0;
        linked[q] <= 1'b0;
        echo[q]   <= '0;
        idc[q]    <= '0;
        tleft[q]  <= '0;
        armed[q]  <= 1'b0;
      end
      now <= '0;
    end else begin
      phase  <= phase_next;
      dkind  <= dkind_next;
      sup    <= sup_next;
      linked <= linked_next;
      echo   <= echo_next;
      idc    <= idc_next;
      tleft  <= tleft_next;
      armed  <= armed_next;
      now    <= now_next;
    end
  end

  always_ff @(posedge clk) begin
    if (idb_we) begin
      idb[port][idb_addr] <= data;
    end
  end

endmodule

// ----- src/pdm_queue.sv -----
module pdm_queue #(
  parameter int DEPTH = pdm_pkg::Q_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pdm_pkg::group_t din,
  output logic            full,
  input  logic            pop,
  output pdm_pkg::group_t dout,
  output logic            valid
);
  import pdm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign dout    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && valid)) |=> count == $past(count) + CNT_W'(1))
    else $error("queue transfer in lost");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && valid && !push) |=> count == $past(count) - CNT_W'(1))
    else $error("queue transfer out miscounted");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
`endif

endmodule

// ----- src/pdm_back.sv -----
module pdm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pdm_pkg::group_t  q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output pdm_pkg::result_t res,
  output logic             last
);
  import pdm_pkg::*;

  group_t hold;
  logic   busy;
  logic   idx;
  logic   done;
  logic   load;

  assign done  = busy && pop && (!hold.two || idx);
  assign load  = !busy || done;
  assign q_pop = load && q_valid;
  assign empty = !busy;
  assign res   = idx ? hold.r1 : hold.r0;
  assign last  = idx || !hold.two;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 1'b0;
    end else if (load) begin
      busy <= q_valid;
      idx  <= 1'b0;
    end else if (pop) begin
      idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold <= q_data;
    end
  end

`ifndef SYNTH
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (busy && pop && hold.two && !idx) |=> (busy && idx))
    else $error("second result of a pair skipped");
`endif

endmodule

// ----- src/ps2_port_device_manager.sv -----
// Path: an accepted item with results is written to the queue at the accepting edge,
// then loaded into the output register when the output side is free. Throughput: one
// item per cycle while the queue is not full; the output register delivers one result
// per cycle while popped, so an item with two results holds it for two transfers.
// The result queue sets slack. Reset: synchronous, active high; clears port state,
// time and queue, loads register defaults; ID byte store is not cleared.
module ps2_port_device_manager #(
  parameter int ID_DEPTH = pdm_pkg::ID_DEPTH_DEF,
  parameter int Q_DEPTH  = pdm_pkg::Q_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [pdm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     op,
  input  logic                           port,
  input  logic [7:0]                     data,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     kind,
  output logic                           port_out,
  output logic [7:0]                     value,
  output logic [2:0]                     device_kind,
  output logic                           translated,
  output logic                           supported,
  output logic                           last
);
  import pdm_pkg::*;

  logic    accept;
  logic    grp_valid;
  group_t  grp;
  logic    q_valid;
  logic    q_pop;
  group_t  q_data;
  result_t res;

  assign accept = push && !full;

  pdm_front #(
    .ID_DEPTH(ID_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op),
    .port      (port),
    .data      (data),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  pdm_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (grp_valid),
    .din   (grp),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_data),
    .valid (q_valid)
  );

  pdm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res),
    .last    (last)
  );

  assign kind        = res.kind;
  assign port_out    = res.port;
  assign value       = res.value;
  assign device_kind = res.dev;
  assign translated  = res.translated;
  assign supported   = res.supported;

endmodule
